[sv/cyrillic_latin_translit_stream_assert.svh]
// Assertion macros for the transliteration stream block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef CYRILLIC_LATIN_TRANSLIT_STREAM_ASSERT_SVH
`define CYRILLIC_LATIN_TRANSLIT_STREAM_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CLTR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cltr assertion failed");

// Next-cycle implication, held off during reset.
`define CLTR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cltr assertion failed");

`endif

[sv/cltr_pkg.sv]
// Shared types, constants and lookup functions for the transliteration stream.
// No dependencies; imported by every module of the block.
package cltr_pkg;

    localparam logic [15:0] RU_BASE  = 16'h0430;
    localparam logic [15:0] RU_LAST  = 16'h044F;
    localparam logic [15:0] EN_BASE  = 16'h0061;
    localparam logic [15:0] EN_LAST  = 16'h007A;

    localparam int NUM_VARIANTS = 3;
    localparam logic [1:0] VAR_PLAIN   = 2'd0;
    localparam logic [1:0] VAR_DIGRAPH = 2'd1;
    localparam logic [1:0] VAR_TRIGR   = 2'd2;

    // Latin letter indices (a = 0)
    localparam logic [4:0] LTR_A = 5'd0;
    localparam logic [4:0] LTR_C = 5'd2;
    localparam logic [4:0] LTR_E = 5'd4;
    localparam logic [4:0] LTR_H = 5'd7;
    localparam logic [4:0] LTR_I = 5'd8;
    localparam logic [4:0] LTR_J = 5'd9;
    localparam logic [4:0] LTR_K = 5'd10;
    localparam logic [4:0] LTR_S = 5'd18;
    localparam logic [4:0] LTR_U = 5'd20;
    localparam logic [4:0] LTR_Y = 5'd24;
    localparam logic [4:0] LTR_Z = 5'd25;

    // Russian letter index for each single Latin letter, padded to 32
    localparam logic [4:0] EN_SINGLE [32] = '{
        5'd0,  5'd1,  5'd22, 5'd4,  5'd5,  5'd20, 5'd3,  5'd21,
        5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
        5'd31, 5'd16, 5'd17, 5'd18, 5'd19, 5'd2,  5'd25, 5'd21,
        5'd9,  5'd7,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };

    typedef struct packed {
        logic [1:0]  erase_count;
        logic [1:0]  append_count;
        logic [15:0] char_first;
        logic [15:0] char_second;
        logic [15:0] char_third;
    } edit_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } spell_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] ru;
    } match_t;

    function automatic spell_t s1(input logic [7:0] a);
        spell_t s;
        s = '{cnt: 2'd1, c0: a, c1: 8'd0, c2: 8'd0};
        return s;
    endfunction

    function automatic spell_t s2(input logic [7:0] a, input logic [7:0] b);
        spell_t s;
        s = '{cnt: 2'd2, c0: a, c1: b, c2: 8'd0};
        return s;
    endfunction

    function automatic spell_t s3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
        spell_t s;
        s = '{cnt: 2'd3, c0: a, c1: b, c2: c};
        return s;
    endfunction

    // Latin spelling of a Russian letter for one variant
    function automatic spell_t ru_spell(input logic [4:0] idx, input logic [1:0] v);
        spell_t s;
        unique case (idx)
            5'd0:  s = s1("a");
            5'd1:  s = s1("b");
            5'd2:  s = s1("v");
            5'd3:  s = s1("g");
            5'd4:  s = s1("d");
            5'd5:  s = s1("e");
            5'd6:  s = s2("z", "h");
            5'd7:  s = s1("z");
            5'd8:  s = s1("i");
            5'd9:  s = s1("y");
            5'd10: s = s1("k");
            5'd11: s = s1("l");
            5'd12: s = s1("m");
            5'd13: s = s1("n");
            5'd14: s = s1("o");
            5'd15: s = s1("p");
            5'd16: s = s1("r");
            5'd17: s = s1("s");
            5'd18: s = s1("t");
            5'd19: s = s1("u");
            5'd20: s = s1("f");
            5'd21: s = s2("k", "h");
            5'd22: s = s1("c");
            5'd23: s = s2("c", "h");
            5'd24: s = s2("s", "h");
            5'd25: s = s3("s", "h", "h");
            5'd26: s = s3("j", "h", "h");
            5'd27: s = s2("i", "h");
            5'd28: s = s2("j", "h");
            5'd29: s = s2("e", "h");
            5'd30: s = s2("j", "u");
            5'd31: s = s2("j", "a");
        endcase
        if (v == VAR_DIGRAPH) begin
            case (idx)
                5'd9:    s = s1("j");
                5'd21:   s = s1("h");
                5'd25:   s = s1("w");
                5'd28:   s = s1("'");
                5'd29:   s = s2("j", "e");
                5'd30:   s = s2("y", "u");
                5'd31:   s = s2("y", "a");
                default: s = s;
            endcase
        end else if (v == VAR_TRIGR) begin
            case (idx)
                5'd21:   s = s1("x");
                5'd31:   s = s1("q");
                default: s = s;
            endcase
        end
        return s;
    endfunction

    // Digraph lookup: first letter a, second letter b
    function automatic match_t find_double(input logic [4:0] a, input logic [4:0] b);
        match_t m;
        m = '{hit: 1'b1, ru: 5'd0};
        if      (a == LTR_Z && b == LTR_H) m.ru = 5'd6;
        else if (a == LTR_K && b == LTR_H) m.ru = 5'd21;
        else if (a == LTR_C && b == LTR_H) m.ru = 5'd23;
        else if (a == LTR_S && b == LTR_H) m.ru = 5'd24;
        else if (a == LTR_I && b == LTR_H) m.ru = 5'd27;
        else if (a == LTR_J && b == LTR_H) m.ru = 5'd28;
        else if (a == LTR_E && b == LTR_H) m.ru = 5'd29;
        else if (a == LTR_J && b == LTR_E) m.ru = 5'd29;
        else if (a == LTR_J && b == LTR_U) m.ru = 5'd30;
        else if (a == LTR_Y && b == LTR_U) m.ru = 5'd30;
        else if (a == LTR_J && b == LTR_A) m.ru = 5'd31;
        else if (a == LTR_Y && b == LTR_A) m.ru = 5'd31;
        else m.hit = 1'b0;
        return m;
    endfunction

    // Trigraph lookup: both trigraphs end in "hh"
    function automatic match_t find_triple(input logic [4:0] a, input logic [4:0] b,
                                           input logic [4:0] c);
        match_t m;
        m = '{hit: 1'b0, ru: 5'd0};
        if (c == LTR_H && b == LTR_H) begin
            if (a == LTR_S) m = '{hit: 1'b1, ru: 5'd25};
            else if (a == LTR_J) m = '{hit: 1'b1, ru: 5'd26};
        end
        return m;
    endfunction

endpackage

[sv/cltr_xlate.sv]
// Edit generator: turns one code unit into three variant edits and
// keeps the Latin letter context. Depends on cltr_pkg.
module cltr_xlate
    import cltr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [15:0] code_unit,
    input  logic        word_start,
    output edit_t       edits [NUM_VARIANTS]
);

    logic [4:0] last_letter_reg, last_letter_next;
    logic [4:0] previous_letter_reg, previous_letter_next;
    logic [1:0] letters_held_reg, letters_held_next;

    logic       is_ru, is_en;
    logic [4:0] ru_idx, en_idx;
    logic [1:0] held_eff;
    logic [15:0] single;
    match_t     dbl, trg;
    spell_t     sp [NUM_VARIANTS];

    assign is_ru    = (code_unit >= RU_BASE) && (code_unit <= RU_LAST);
    assign is_en    = (code_unit >= EN_BASE) && (code_unit <= EN_LAST);
    assign ru_idx   = 5'(code_unit - RU_BASE);
    assign en_idx   = 5'(code_unit - EN_BASE);
    assign held_eff = word_start ? 2'd0 : letters_held_reg;
    assign single   = RU_BASE + {11'd0, EN_SINGLE[en_idx]};
    assign dbl      = find_double(last_letter_reg, en_idx);
    assign trg      = find_triple(previous_letter_reg, last_letter_reg, en_idx);

    always_comb
    begin
        for (int v = 0; v < NUM_VARIANTS; v++) begin
            sp[v] = ru_spell(ru_idx, 2'(v));
        end
    end

    always_comb
    begin
        for (int v = 0; v < NUM_VARIANTS; v++) begin
            edits[v] = '{erase_count: 2'd0, append_count: 2'd1,
                         char_first: code_unit, char_second: 16'd0, char_third: 16'd0};
        end
        if (is_ru) begin
            for (int v = 0; v < NUM_VARIANTS; v++) begin
                edits[v].append_count = sp[v].cnt;
                edits[v].char_first   = {8'd0, sp[v].c0};
                edits[v].char_second  = {8'd0, sp[v].c1};
                edits[v].char_third   = {8'd0, sp[v].c2};
            end
        end else if (is_en) begin
            for (int v = 0; v < NUM_VARIANTS; v++) begin
                edits[v].char_first = single;
            end
            if (held_eff != 2'd0 && dbl.hit) begin
                edits[VAR_DIGRAPH].erase_count = 2'd1;
                edits[VAR_DIGRAPH].char_first  = RU_BASE + {11'd0, dbl.ru};
            end
            if (held_eff == 2'd2 && trg.hit) begin
                edits[VAR_TRIGR].erase_count = 2'd2;
                edits[VAR_TRIGR].char_first  = RU_BASE + {11'd0, trg.ru};
            end
        end
    end

    // Context: only a Latin letter pushes; anything else empties it
    always_comb
    begin
        last_letter_next     = last_letter_reg;
        previous_letter_next = previous_letter_reg;
        letters_held_next    = letters_held_reg;
        if (load) begin
            if (is_en) begin
                last_letter_next = en_idx;
                if (held_eff != 2'd0) begin
                    previous_letter_next = last_letter_reg;
                    letters_held_next    = 2'd2;
                end else begin
                    letters_held_next = 2'd1;
                end
            end else begin
                letters_held_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_letter_reg     <= 5'd0;
            previous_letter_reg <= 5'd0;
            letters_held_reg    <= 2'd0;
        end else begin
            last_letter_reg     <= last_letter_next;
            previous_letter_reg <= previous_letter_next;
            letters_held_reg    <= letters_held_next;
        end
    end

endmodule

[sv/cltr_outq.sv]
// Result register: holds the three edits of one item and hands them out
// in variant order. Depends on cltr_pkg.
module cltr_outq
    import cltr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  edit_t       edits [NUM_VARIANTS],
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  variant,
    output logic [1:0]  erase_count,
    output logic [1:0]  append_count,
    output logic [15:0] char_first,
    output logic [15:0] char_second,
    output logic [15:0] char_third,
    output logic        last_of_run
);

    edit_t      buf_reg [NUM_VARIANTS];
    logic       valid_reg, valid_next;
    logic [1:0] sel_reg, sel_next;
    logic       take, last;

    assign last     = (sel_reg == VAR_TRIGR);
    assign take     = valid_reg && out_ready;
    assign can_load = !valid_reg || (take && last);

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load) begin
            valid_next = 1'b1;
            sel_next   = VAR_PLAIN;
        end else if (take) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                sel_next = sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            sel_reg   <= VAR_PLAIN;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            buf_reg <= edits;
        end
    end

    assign out_valid    = valid_reg;
    assign variant      = sel_reg;
    assign erase_count  = buf_reg[sel_reg].erase_count;
    assign append_count = buf_reg[sel_reg].append_count;
    assign char_first   = buf_reg[sel_reg].char_first;
    assign char_second  = buf_reg[sel_reg].char_second;
    assign char_third   = buf_reg[sel_reg].char_third;
    assign last_of_run  = last;

endmodule

[sv/cyrillic_latin_translit_stream.sv]
// Top level of the Russian/Latin transliteration edit stream.
// Instantiates cltr_xlate and cltr_outq; uses cltr_pkg and the assert header.
//
// Usage:
//  - Input channel (in_valid/in_ready): one UTF-16 code unit of a word per
//    transaction, with word_start set on the first character of a word.
//  - Output channel (out_valid/out_ready): three edit transactions per input,
//    variants 0, 1 and 2 in that order; last_of_run marks the variant 2 edit.
//  - Each edit: erase erase_count characters from that variant's string, then
//    append append_count characters (char_first, char_second, char_third).
//  - Path: an accepted input waits in the input register, moves into the result
//    register once that is free, and its edits are shown from there; the input
//    register takes the next item while edits are still draining.
//  - Output sharing: the three edits of an item share the single output channel,
//    so the next item loads only as the variant 2 edit of the last is taken.
//  - Receiver stall: edits hold steady; once the input register is also full
//    in_ready drops until the result register frees.
//  - Reset: all channels empty, letter context cleared.
module cyrillic_latin_translit_stream
    import cltr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        word_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  variant,
    output logic [1:0]  erase_count,
    output logic [1:0]  append_count,
    output logic [15:0] char_first,
    output logic [15:0] char_second,
    output logic [15:0] char_third,
    output logic        last_of_run
);

    `include "cyrillic_latin_translit_stream_assert.svh"

    // Input register
    logic        hold_valid_reg, hold_valid_next;
    logic [15:0] code_reg;
    logic        word_start_reg;

    logic  can_load, load, in_take;
    edit_t edits [NUM_VARIANTS];

    // Item moves into the result register as soon as it is free
    assign load     = hold_valid_reg && can_load;
    assign in_ready = !hold_valid_reg || load;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_take) begin
            hold_valid_next = 1'b1;
        end else if (load) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            code_reg       <= code_unit;
            word_start_reg <= word_start;
        end
    end

    // Edit generation and letter context
    cltr_xlate u_xlate (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .code_unit  (code_reg),
        .word_start (word_start_reg),
        .edits      (edits)
    );

    // Result register and output sequencing
    cltr_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .edits        (edits),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .variant      (variant),
        .erase_count  (erase_count),
        .append_count (append_count),
        .char_first   (char_first),
        .char_second  (char_second),
        .char_third   (char_third),
        .last_of_run  (last_of_run)
    );

    // Variants are delivered strictly in order within an item
    `CLTR_ASSERT_NXT(a_variant_order, out_valid && out_ready && !last_of_run,
                     out_valid && variant == 2'($past(variant) + 2'd1))

    // An erase only ever drops the context that variant could have built
    `CLTR_ASSERT_IMP(a_erase_shape, out_valid && erase_count != 2'd0,
                     erase_count == variant && append_count == 2'd1)

    // Input side only backs up when an item is already waiting
    `CLTR_ASSERT_IMP(a_ready_hold, !in_ready, hold_valid_reg && out_valid)

endmodule

[tb/cltr_edit_checker.sv]
// Scoreboard for the transliteration edit stream: watches both channels,
// predicts the three edits of every accepted character and compares them.
// Depends on cltr_pkg for base codes, variant and letter constants.
module cltr_edit_checker
    import cltr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        word_start,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  variant,
    input  logic [1:0]  erase_count,
    input  logic [1:0]  append_count,
    input  logic [15:0] char_first,
    input  logic [15:0] char_second,
    input  logic [15:0] char_third,
    input  logic        last_of_run,
    output int          mismatch_count,
    output int          edits_outstanding,
    output int          edits_checked,
    output int          digraph_hits,
    output int          trigraph_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  vsel;
        logic [1:0]  erase;
        logic [1:0]  count;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic        last;
    } edit_rec_t;

    edit_rec_t   expected_edits[$];
    logic [4:0]  ctx_last;
    logic [4:0]  ctx_prev;
    logic [1:0]  ctx_count;
    int          errors;
    int          checked;
    int          pair_count;
    int          triple_count;

    // Latin spelling of Russian letter idx, right aligned, one byte per char
    function automatic logic [23:0] latin_spelling(input logic [4:0] idx,
                                                   input logic [1:0] vsel);
        logic [23:0] s;
        case (idx)
            5'd0:    s = "a";
            5'd1:    s = "b";
            5'd2:    s = "v";
            5'd3:    s = "g";
            5'd4:    s = "d";
            5'd5:    s = "e";
            5'd6:    s = "zh";
            5'd7:    s = "z";
            5'd8:    s = "i";
            5'd9:    s = "y";
            5'd10:   s = "k";
            5'd11:   s = "l";
            5'd12:   s = "m";
            5'd13:   s = "n";
            5'd14:   s = "o";
            5'd15:   s = "p";
            5'd16:   s = "r";
            5'd17:   s = "s";
            5'd18:   s = "t";
            5'd19:   s = "u";
            5'd20:   s = "f";
            5'd21:   s = "kh";
            5'd22:   s = "c";
            5'd23:   s = "ch";
            5'd24:   s = "sh";
            5'd25:   s = "shh";
            5'd26:   s = "jhh";
            5'd27:   s = "ih";
            5'd28:   s = "jh";
            5'd29:   s = "eh";
            5'd30:   s = "ju";
            default: s = "ja";
        endcase
        if (vsel == VAR_DIGRAPH) begin
            case (idx)
                5'd9:    s = "j";
                5'd21:   s = "h";
                5'd25:   s = "w";
                5'd28:   s = "'";
                5'd29:   s = "je";
                5'd30:   s = "yu";
                5'd31:   s = "ya";
                default: s = s;
            endcase
        end else if (vsel == VAR_TRIGR) begin
            case (idx)
                5'd21:   s = "x";
                5'd31:   s = "q";
                default: s = s;
            endcase
        end
        return s;
    endfunction

    // Russian letter index for a single Latin letter (a = 0)
    function automatic logic [4:0] latin_to_ru(input logic [4:0] n);
        logic [4:0] r;
        case (n)
            5'd0:    r = 5'd0;
            5'd1:    r = 5'd1;
            5'd2:    r = 5'd22;
            5'd3:    r = 5'd4;
            5'd4:    r = 5'd5;
            5'd5:    r = 5'd20;
            5'd6:    r = 5'd3;
            5'd7:    r = 5'd21;
            5'd8:    r = 5'd8;
            5'd9:    r = 5'd9;
            5'd10:   r = 5'd10;
            5'd11:   r = 5'd11;
            5'd12:   r = 5'd12;
            5'd13:   r = 5'd13;
            5'd14:   r = 5'd14;
            5'd15:   r = 5'd15;
            5'd16:   r = 5'd31;
            5'd17:   r = 5'd16;
            5'd18:   r = 5'd17;
            5'd19:   r = 5'd18;
            5'd20:   r = 5'd19;
            5'd21:   r = 5'd2;
            5'd22:   r = 5'd25;
            5'd23:   r = 5'd21;
            5'd24:   r = 5'd9;
            default: r = 5'd7;
        endcase
        return r;
    endfunction

    // {hit, russian index} for the letter pair a then b
    function automatic logic [5:0] digraph_ru(input logic [4:0] a, input logic [4:0] b);
        if (a == LTR_Z && b == LTR_H) return {1'b1, 5'd6};
        if (a == LTR_K && b == LTR_H) return {1'b1, 5'd21};
        if (a == LTR_C && b == LTR_H) return {1'b1, 5'd23};
        if (a == LTR_S && b == LTR_H) return {1'b1, 5'd24};
        if (a == LTR_I && b == LTR_H) return {1'b1, 5'd27};
        if (a == LTR_J && b == LTR_H) return {1'b1, 5'd28};
        if (a == LTR_E && b == LTR_H) return {1'b1, 5'd29};
        if (a == LTR_J && b == LTR_E) return {1'b1, 5'd29};
        if (a == LTR_J && b == LTR_U) return {1'b1, 5'd30};
        if (a == LTR_Y && b == LTR_U) return {1'b1, 5'd30};
        if (a == LTR_J && b == LTR_A) return {1'b1, 5'd31};
        if (a == LTR_Y && b == LTR_A) return {1'b1, 5'd31};
        return 6'd0;
    endfunction

    // Only "shh" and "jhh" exist
    function automatic logic [5:0] trigraph_ru(input logic [4:0] a, input logic [4:0] b,
                                               input logic [4:0] c);
        if (b != LTR_H || c != LTR_H) return 6'd0;
        if (a == LTR_S) return {1'b1, 5'd25};
        if (a == LTR_J) return {1'b1, 5'd26};
        return 6'd0;
    endfunction

    function automatic edit_rec_t make_edit(input logic [1:0] vsel, input logic [1:0] erase,
                                            input logic [1:0] count, input logic [15:0] c0,
                                            input logic [15:0] c1, input logic [15:0] c2);
        edit_rec_t e;
        e = '{vsel: vsel, erase: erase, count: count, c0: c0, c1: c1, c2: c2,
              last: (vsel == VAR_TRIGR)};
        return e;
    endfunction

    task automatic transliterate_char(input logic [15:0] cu, input logic ws);
        logic [15:0] offs;
        logic [4:0]  n;
        logic [15:0] single;
        logic [5:0]  pair;
        logic [5:0]  triple;
        logic [23:0] spelled;
        logic [1:0]  cnt;
        logic [1:0]  vsel;
        if (ws)
            ctx_count = 2'd0;
        if (cu >= RU_BASE && cu <= RU_LAST) begin
            offs = cu - RU_BASE;
            for (int v = 0; v < NUM_VARIANTS; v++) begin
                vsel    = v[1:0];
                spelled = latin_spelling(offs[4:0], vsel);
                cnt     = (spelled[23:16] != 8'd0) ? 2'd3 :
                          (spelled[15:8] != 8'd0)  ? 2'd2 : 2'd1;
                // left align so the first character sits in the top byte
                spelled = spelled << (8 * (3 - cnt));
                expected_edits.push_back(make_edit(vsel, 2'd0, cnt, {8'h00, spelled[23:16]},
                                                   {8'h00, spelled[15:8]},
                                                   {8'h00, spelled[7:0]}));
            end
            ctx_count = 2'd0;
        end else if (cu >= EN_BASE && cu <= EN_LAST) begin
            offs   = cu - EN_BASE;
            n      = offs[4:0];
            single = RU_BASE + {11'd0, latin_to_ru(n)};
            expected_edits.push_back(make_edit(VAR_PLAIN, 2'd0, 2'd1, single, 16'd0, 16'd0));

            pair = (ctx_count > 2'd0) ? digraph_ru(ctx_last, n) : 6'd0;
            if (pair[5]) begin
                pair_count++;
                expected_edits.push_back(make_edit(VAR_DIGRAPH, 2'd1, 2'd1,
                                                   RU_BASE + {11'd0, pair[4:0]}, 16'd0, 16'd0));
            end else
                expected_edits.push_back(make_edit(VAR_DIGRAPH, 2'd0, 2'd1, single,
                                                   16'd0, 16'd0));

            triple = (ctx_count > 2'd1) ? trigraph_ru(ctx_prev, ctx_last, n) : 6'd0;
            if (ctx_count > 2'd0) begin
                ctx_prev  = ctx_last;
                ctx_count = 2'd2;
            end else
                ctx_count = 2'd1;
            ctx_last = n;
            if (triple[5]) begin
                triple_count++;
                expected_edits.push_back(make_edit(VAR_TRIGR, 2'd2, 2'd1,
                                                   RU_BASE + {11'd0, triple[4:0]}, 16'd0, 16'd0));
            end else
                expected_edits.push_back(make_edit(VAR_TRIGR, 2'd0, 2'd1, single,
                                                   16'd0, 16'd0));
        end else begin
            for (int v = 0; v < NUM_VARIANTS; v++) begin
                vsel = v[1:0];
                expected_edits.push_back(make_edit(vsel, 2'd0, 2'd1, cu, 16'd0, 16'd0));
            end
            ctx_count = 2'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        edit_rec_t seen;
        edit_rec_t want;
        if (!rst_n) begin
            expected_edits.delete();
            ctx_last          = 5'd0;
            ctx_prev          = 5'd0;
            ctx_count         = 2'd0;
            errors            = 0;
            checked           = 0;
            pair_count        = 0;
            triple_count      = 0;
            mismatch_count    <= 0;
            edits_outstanding <= 0;
            edits_checked     <= 0;
            digraph_hits      <= 0;
            trigraph_hits     <= 0;
        end else begin
            // results first, so an edit with nothing queued is caught
            if (out_valid && out_ready) begin
                seen = '{vsel: variant, erase: erase_count, count: append_count,
                         c0: char_first, c1: char_second, c2: char_third,
                         last: last_of_run};
                if (expected_edits.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected edit: var %0d erase %0d app %0d %h %h %h last %0b",
                                 $realtime, seen.vsel, seen.erase, seen.count,
                                 seen.c0, seen.c1, seen.c2, seen.last);
                end else begin
                    want = expected_edits.pop_front();
                    checked++;
                    if (seen != want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("[%0t] edit mismatch", $realtime);
                            $display("  exp: var %0d erase %0d app %0d %h %h %h last %0b",
                                     want.vsel, want.erase, want.count,
                                     want.c0, want.c1, want.c2, want.last);
                            $display("  got: var %0d erase %0d app %0d %h %h %h last %0b",
                                     seen.vsel, seen.erase, seen.count,
                                     seen.c0, seen.c1, seen.c2, seen.last);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                transliterate_char(code_unit, word_start);
            mismatch_count    <= errors;
            edits_outstanding <= expected_edits.size();
            edits_checked     <= checked;
            digraph_hits      <= pair_count;
            trigraph_hits     <= triple_count;
        end
    end

endmodule

[tb/tb_cyrillic_latin_translit_stream.sv]
// Top of the transliteration edit stream testbench: clock, reset, stimulus,
// receiver back-pressure and the verdict. Uses cltr_pkg, the block itself
// and cltr_edit_checker, which does all prediction and comparison.
module tb_cyrillic_latin_translit_stream
    import cltr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 470;
    // Watchdog limit, kept well clear of the slowest legal run
    localparam int CYCLE_LIMIT  = 400000;
    // Block shows its first edit from the result register, behind the input register
    localparam int TAIL_CYCLES  = 8;

    typedef enum logic [1:0] {SINK_FREE, SINK_CHOPPY, SINK_TRICKLE} sink_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] code_unit = 16'd0;
    logic        word_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  variant;
    logic [1:0]  erase_count;
    logic [1:0]  append_count;
    logic [15:0] char_first;
    logic [15:0] char_second;
    logic [15:0] char_third;
    logic        last_of_run;

    int mismatch_count;
    int edits_outstanding;
    int edits_checked;
    int digraph_hits;
    int trigraph_hits;

    int chars_sent;
    int burst_left;
    int cycle_count;

    sink_mode_t sink_mode = SINK_FREE;
    int         sink_left = 0;
    int         hold_left = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    cyrillic_latin_translit_stream uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_unit    (code_unit),
        .word_start   (word_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .variant      (variant),
        .erase_count  (erase_count),
        .append_count (append_count),
        .char_first   (char_first),
        .char_second  (char_second),
        .char_third   (char_third),
        .last_of_run  (last_of_run)
    );

    cltr_edit_checker edit_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .code_unit         (code_unit),
        .word_start        (word_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .variant           (variant),
        .erase_count       (erase_count),
        .append_count      (append_count),
        .char_first        (char_first),
        .char_second       (char_second),
        .char_third        (char_third),
        .last_of_run       (last_of_run),
        .mismatch_count    (mismatch_count),
        .edits_outstanding (edits_outstanding),
        .edits_checked     (edits_checked),
        .digraph_hits      (digraph_hits),
        .trigraph_hits     (trigraph_hits)
    );

    // Receiver: switches at random between three stall behaviours - always
    // ready, coin-toss ready, and a trickle where ready pulses once after
    // each random hold. Any of the modes can fill the input register and
    // push in_ready low.
    always @(posedge clk) begin
        if (sink_left == 0) begin
            sink_mode <= sink_mode_t'($urandom_range(0, 2));
            sink_left <= $urandom_range(40, 160);
        end else
            sink_left <= sink_left - 1;
        case (sink_mode)
            SINK_FREE:   out_ready <= 1'b1;
            SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
            default:
                if (hold_left == 0) begin
                    out_ready <= 1'b1;
                    hold_left <= $urandom_range(1, 12);
                end else begin
                    out_ready <= 1'b0;
                    hold_left <= hold_left - 1;
                end
        endcase
    end

    // Watchdog: a hung handshake or a lost edit ends here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d edits still expected",
                 cycle_count, edits_outstanding);
        $display("cyrillic_latin_translit_stream verification failed");
        $finish;
    end

    // One input transaction. The sender works in bursts; at the start of
    // each burst it may drop valid for a random gap. A zero gap keeps valid
    // high across bursts, giving stretches with no idling at all. Valid is
    // only lowered when a gap really follows, so it never sees two
    // nonblocking writes in one time step.
    task automatic send_char(input logic [15:0] cu, input logic ws);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        code_unit  <= cu;
        word_start <= ws;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        chars_sent++;
    endtask

    // Hold the sender off until every predicted edit has come back. The
    // checker's counters are registered, so the count is only trusted once
    // it has been updated after the last transaction.
    task automatic wait_for_edits();
        in_valid <= 1'b0;
        @(posedge clk);
        while (edits_outstanding != 0) @(posedge clk);
    endtask

    // Mostly Latin letters weighted towards the ones that form digraphs
    // and trigraphs, then Cyrillic, codes either side of both ranges, and
    // raw 16-bit noise so every bit of code_unit toggles.
    function automatic logic [15:0] pick_code();
        string      hot;
        int         r;
        logic [7:0] ch;
        hot = "shzcjkyieauh";
        r   = $urandom_range(0, 99);
        if (r < 32) begin
            ch = hot[$urandom_range(0, 11)];
            return {8'h00, ch};
        end
        if (r < 50)
            return EN_BASE + 16'($urandom_range(0, 25));
        if (r < 72)
            return RU_BASE + 16'($urandom_range(0, 31));
        if (r < 84) begin
            case ($urandom_range(0, 7))
                0:       return RU_BASE - 16'd1;
                1:       return RU_LAST + 16'd1;
                2:       return EN_BASE - 16'd1;
                3:       return EN_LAST + 16'd1;
                4:       return 16'h0041 + 16'($urandom_range(0, 25));
                5:       return 16'h0030 + 16'($urandom_range(0, 9));
                6:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        int  random_sent;
        int  word_len;
        bit  drained_mid;
        chars_sent  = 0;
        burst_left  = 0;
        random_sent = 0;
        drained_mid = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // code unit extremes and the edges of the Cyrillic block
        send_char(16'h0000, 1'b1);
        send_char(16'hFFFF, 1'b0);
        send_char(RU_BASE, 1'b0);
        send_char(RU_LAST, 1'b0);
        send_char(RU_BASE - 16'd1, 1'b0);
        send_char(RU_LAST + 16'd1, 1'b0);
        // "shh": digraph on the second letter, trigraph on the third
        send_char(16'("s"), 1'b1);
        send_char(16'("h"), 1'b0);
        send_char(16'("h"), 1'b0);
        // "jhh", then a letter with a stale "hh" context
        send_char(16'("j"), 1'b1);
        send_char(16'("h"), 1'b0);
        send_char(16'("h"), 1'b0);
        send_char(16'("z"), 1'b0);
        // "ya" then "ju" carried on in the same word
        send_char(16'("y"), 1'b1);
        send_char(16'("a"), 1'b0);
        send_char(16'("j"), 1'b0);
        send_char(16'("u"), 1'b0);
        // Cyrillic between two letters breaks the pair
        send_char(16'("s"), 1'b0);
        send_char(RU_BASE + 16'd6, 1'b0);
        send_char(16'("h"), 1'b0);
        // word start between two letters breaks the pair
        send_char(16'("c"), 1'b0);
        send_char(16'("h"), 1'b1);
        // uppercase, digit and the codes either side of a..z pass through
        send_char(16'h0041, 1'b0);
        send_char(16'h0030, 1'b0);
        send_char(EN_BASE - 16'd1, 1'b0);
        send_char(EN_LAST + 16'd1, 1'b0);
        send_char(EN_LAST, 1'b0);

        // let the pipe run dry once before the random words
        wait_for_edits();

        // --- random words ---
        while (random_sent < RANDOM_ITEMS) begin
            if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
                wait_for_edits();
                drained_mid = 1'b1;
            end
            // some words open with a ready-made trigraph
            if ($urandom_range(0, 5) == 0) begin
                send_char(($urandom_range(0, 1) != 0) ? 16'("s") : 16'("j"), 1'b1);
                send_char(16'("h"), 1'b0);
                send_char(16'("h"), 1'b0);
                random_sent += 3;
                word_len = $urandom_range(0, 5);
            end else begin
                send_char(pick_code(), 1'b1);
                random_sent++;
                word_len = $urandom_range(0, 7);
            end
            // stray word_start mid-word now and then
            for (int k = 0; k < word_len; k++) begin
                send_char(pick_code(), $urandom_range(0, 19) == 0);
                random_sent++;
            end
        end

        wait_for_edits();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d characters, %0d edits checked in order against the predictor",
                 chars_sent, edits_checked);
        $display("including %0d digraph and %0d trigraph replacements under random stalls",
                 digraph_hits, trigraph_hits);
        if (mismatch_count == 0 && edits_outstanding == 0)
            $display("cyrillic_latin_translit_stream verification clean");
        else
            $display("cyrillic_latin_translit_stream verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/cltr_pkg.sv
sv/cltr_xlate.sv
sv/cltr_outq.sv
sv/cyrillic_latin_translit_stream.sv
tb/cltr_edit_checker.sv
tb/tb_cyrillic_latin_translit_stream.sv
